FILE: rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants and helpers of the bitmap slot allocator: word geometry
// of the free map, command and outcome codes, lowest-set-bit search.
// ----------------------------------------------------------------------------
package bsa_pkg;

   // Free map word geometry
   localparam int WORD_W    = 64;
   localparam int WORD_BITS = 6;

   // Width of the slot index fields on the channels
   localparam int INDEX_W = 12;

   // Default table size
   localparam int DEFAULT_SLOT_COUNT = 4096;

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Outcome codes
   localparam logic OUTCOME_DONE = 1'b0;
   localparam logic OUTCOME_FULL = 1'b1;

   // Position of the lowest set bit of a word; zero when the word is empty
   function automatic logic [WORD_BITS-1:0] lowest_set(input logic [WORD_W-1:0] word);
      logic [WORD_BITS-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            pos = WORD_BITS'(i);
         end
      end
      return pos;
   endfunction

endpackage

FILE: rtl/bsa_chan_if.sv
// ----------------------------------------------------------------------------
// bsa_req_if / bsa_rsp_if
// Valid/ready channels of the allocator: command items in, result items out.
// ----------------------------------------------------------------------------
interface bsa_req_if
   import bsa_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [INDEX_W-1:0] release_index;

   modport source (output valid, output command, output release_index, input ready);
   modport sink   (input valid, input command, input release_index, output ready);
endinterface

interface bsa_rsp_if
   import bsa_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] granted_index;
   logic               outcome;

   modport source (output valid, output granted_index, output outcome, input ready);
   modport sink   (input valid, input granted_index, input outcome, output ready);
endinterface

FILE: rtl/bsa_ram.sv
// ----------------------------------------------------------------------------
// bsa_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module bsa_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Next-fit slot allocator over a bitmap of free flags held in a word RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries command items: an allocate (command 0) or a free of
//   release_index (command 1). rsp_bus returns one result item per command:
//   granted_index for a successful allocate, outcome 1 when no slot is free.
//   An allocate scans 64-slot words upward from the fresh pointer, then from
//   word 0 if that region holds nothing free. The RAM is read one word per
//   cycle in a pipelined scan; the hit word is written back in the cycle it
//   is examined.
//   A free in range passes through S_FREE, one out of range goes straight
//   to S_DONE; an allocate passes through S_SCAN, examining one word per
//   step, and then S_DONE. One item is in work at a time; the next is
//   taken as soon as the result is in the output register.
//   After reset a clearing pass writes all ceil(SLOT_COUNT / 64) words free
//   (64 at the default size), with req_bus.ready low.
//   When the receiver stalls, the result waits in the output register; one
//   more item is taken and finished, then held until that register frees.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator
   import bsa_pkg::*;
#(
   parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   bsa_req_if.sink    req_bus,
   bsa_rsp_if.source  rsp_bus
);

   localparam int WORDS     = (SLOT_COUNT + WORD_W - 1) / WORD_W;
   localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SLOT_W    = WADDR_W + WORD_BITS;
   localparam int PTR_W     = SLOT_W + 1;
   localparam int EXT_W     = ((SLOT_W > INDEX_W) ? SLOT_W : INDEX_W) + 1;
   localparam int LAST_WORD = WORDS - 1;
   localparam int LAST_BITS = SLOT_COUNT - LAST_WORD * WORD_W;

   localparam logic [WADDR_W-1:0] LAST_ADDR = WADDR_W'(LAST_WORD);
   localparam logic [WORD_W-1:0]  HI_MASK   = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
   localparam logic [PTR_W-1:0]   PTR_END   = PTR_W'(SLOT_COUNT);
   localparam logic [EXT_W-1:0]   EXT_END   = EXT_W'(SLOT_COUNT);

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FREE  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [WADDR_W-1:0]   scan_addr_ff, scan_addr_in;
   logic [WADDR_W-1:0]   chk_addr_ff, chk_addr_in;
   logic                 fresh_ff, fresh_in;
   logic [WORD_BITS-1:0] bit_ff, bit_in;
   logic [PTR_W-1:0]     fp_ff, fp_in;
   logic [INDEX_W-1:0]   res_index_ff, res_index_in;
   logic                 res_outcome_ff, res_outcome_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                 rsp_outcome_ff, rsp_outcome_in;

   logic                 ram_wr_en;
   logic [WADDR_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]    ram_wr_data;
   logic [WADDR_W-1:0]   ram_rd_addr;
   logic [WORD_W-1:0]    ram_rd_data;

   logic                 req_fire;
   logic                 fresh_ok;
   logic [WADDR_W-1:0]   fp_word;
   logic [WORD_BITS-1:0] fp_bit;
   logic [EXT_W-1:0]     rel_ext;
   logic                 rel_ok;
   logic [WORD_W-1:0]    lo_mask;
   logic [WORD_W-1:0]    avail;
   logic                 hit;
   logic [WORD_BITS-1:0] hit_bit;
   logic [SLOT_W-1:0]    grant_slot;

   bsa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS),
      .ADDR_W(WADDR_W)
   ) u_free_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Fresh region start
   assign fresh_ok = (fp_ff < PTR_END);
   assign fp_word  = fp_ff[WORD_BITS +: WADDR_W];
   assign fp_bit   = fp_ff[WORD_BITS-1:0];

   // Release index range check
   assign rel_ext = EXT_W'(req_bus.release_index);
   assign rel_ok  = (rel_ext < EXT_END);

   // Mask the word under test to the region being searched
   assign lo_mask = (fresh_ff && (chk_addr_ff == fp_word)) ?
                    ({WORD_W{1'b1}} << fp_bit) : {WORD_W{1'b1}};
   assign avail   = ram_rd_data & lo_mask &
                    ((chk_addr_ff == LAST_ADDR) ? HI_MASK : {WORD_W{1'b1}});
   assign hit        = |avail;
   assign hit_bit    = lowest_set(avail);
   assign grant_slot = {chk_addr_ff, hit_bit};

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      scan_addr_in   = scan_addr_ff;
      chk_addr_in    = chk_addr_ff;
      fresh_in       = fresh_ff;
      bit_in         = bit_ff;
      fp_in          = fp_ff;
      res_index_in   = res_index_ff;
      res_outcome_in = res_outcome_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = chk_addr_ff;
      ram_wr_data    = {WORD_W{1'b1}};
      ram_rd_addr    = scan_addr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
            if (chk_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               chk_addr_in = chk_addr_ff + WADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               res_index_in   = '0;
               res_outcome_in = OUTCOME_DONE;
               if (req_bus.command == CMD_FREE) begin
                  ram_rd_addr = rel_ext[WORD_BITS +: WADDR_W];
                  chk_addr_in = rel_ext[WORD_BITS +: WADDR_W];
                  bit_in      = rel_ext[WORD_BITS-1:0];
                  state_in    = rel_ok ? S_FREE : S_DONE;
               end else begin
                  // Start in the fresh region if it is not exhausted
                  fresh_in    = fresh_ok;
                  ram_rd_addr = fresh_ok ? fp_word : '0;
                  chk_addr_in = ram_rd_addr;
                  scan_addr_in = (ram_rd_addr == LAST_ADDR) ? ram_rd_addr :
                                 ram_rd_addr + WADDR_W'(1);
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue the next word while testing the current one
            chk_addr_in  = scan_addr_ff;
            scan_addr_in = (scan_addr_ff == LAST_ADDR) ? scan_addr_ff :
                           scan_addr_ff + WADDR_W'(1);
            if (hit) begin
               ram_wr_en    = 1'b1;
               ram_wr_data  = ram_rd_data & ~(WORD_W'(1) << hit_bit);
               res_index_in = INDEX_W'(grant_slot);
               fp_in        = fresh_ff ? PTR_W'(grant_slot) + PTR_W'(1) : PTR_END;
               state_in     = S_DONE;
            end else if (chk_addr_ff == LAST_ADDR) begin
               if (fresh_ff) begin
                  // Wrap around and search from word 0
                  fresh_in     = 1'b0;
                  ram_rd_addr  = '0;
                  chk_addr_in  = '0;
                  scan_addr_in = (LAST_ADDR == '0) ? '0 : WADDR_W'(1);
               end else begin
                  res_outcome_in = OUTCOME_FULL;
                  state_in       = S_DONE;
               end
            end
         end
         S_FREE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data | (WORD_W'(1) << bit_ff);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_index_in   = rsp_index_ff;
      rsp_outcome_in = rsp_outcome_ff;
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready)) begin
         rsp_valid_in   = 1'b1;
         rsp_index_in   = res_index_ff;
         rsp_outcome_in = res_outcome_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         chk_addr_ff  <= '0;
         scan_addr_ff <= '0;
         fresh_ff     <= 1'b0;
         fp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_addr_ff  <= chk_addr_in;
         scan_addr_ff <= scan_addr_in;
         fresh_ff     <= fresh_in;
         fp_ff        <= fp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bit_ff         <= bit_in;
      res_index_ff   <= res_index_in;
      res_outcome_ff <= res_outcome_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.granted_index = rsp_index_ff;
   assign rsp_bus.outcome       = rsp_outcome_ff;

   // A result appears only out of the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result item raised outside completion");

   // A grant write-back clears exactly one free flag
   a_grant_one_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && ram_wr_en) |-> $countones(ram_rd_data ^ ram_wr_data) == 1)
      else $error("grant write-back changed other than one flag");

   // A release write-back changes at most one flag
   a_free_one_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE) |-> $countones(ram_rd_data ^ ram_wr_data) <= 1)
      else $error("release write-back changed more than one flag");

   // The fresh pointer never runs past the table end
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      fp_ff <= PTR_END)
      else $error("fresh pointer beyond slot count");

endmodule
